>>> rtl/z80acc_pkg.sv
// Shared types and command codes for the Z80 accumulator, flag and
// interrupt-control block. No dependencies.
`timescale 1ns / 1ps

package z80acc_pkg;

  typedef enum logic [3:0] {
    CMD_NOP = 4'd0,
    CMD_DAA = 4'd1,
    CMD_CPL = 4'd2,
    CMD_NEG = 4'd3,
    CMD_CCF = 4'd4,
    CMD_SCF = 4'd5,
    CMD_HALT = 4'd6,
    CMD_DI = 4'd7,
    CMD_EI = 4'd8,
    CMD_IM0 = 4'd9,
    CMD_IM1 = 4'd10,
    CMD_IM2 = 4'd11
  } cmd_t;

  localparam logic [1:0] IM_MODE0 = 2'd0;
  localparam logic [1:0] IM_MODE1 = 2'd1;
  localparam logic [1:0] IM_MODE2 = 2'd2;

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] acc_in;
    logic [7:0] flags_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic [7:0] flags_out;
    logic       iff1_out;
    logic       iff2_out;
    logic [1:0] int_mode_out;
    logic       halt_request;
    logic       ei_executed;
  } out_item_t;

endpackage

>>> rtl/z80_accumulator_flag_and_int_control.sv
// Two register stages, the input register and the result register; out_valid is
// registered and rises when an item moves from the input register to the result one.
// Throughput: one item per cycle unless out_valid is high with out_ready low (stall).
// Reset (rst_n low, synchronous): pipeline emptied, IFF1/IFF2 cleared, interrupt mode 0.
// Top level of the Z80 accumulator/flag and interrupt-control block.
// Depends on z80acc_pkg and z80acc_alu.
`timescale 1ns / 1ps

module z80_accumulator_flag_and_int_control (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  z80acc_pkg::in_item_t   in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output z80acc_pkg::out_item_t  out_item
);

  logic                  s1_valid_r;
  z80acc_pkg::in_item_t  s1_item_r;
  logic                  out_valid_r;
  z80acc_pkg::out_item_t out_item_r;
  z80acc_pkg::out_item_t out_item_nxt;

  logic       iff1_r, iff1_nxt;
  logic       iff2_r, iff2_nxt;
  logic [1:0] im_r, im_nxt;

  logic       adv;
  logic [7:0] acc_res;
  logic [7:0] flags_res;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  z80acc_alu u_alu (
    .cmd       (s1_item_r.cmd),
    .acc       (s1_item_r.acc_in),
    .flags     (s1_item_r.flags_in),
    .acc_res   (acc_res),
    .flags_res (flags_res)
  );

  always_comb begin
    iff1_nxt = iff1_r;
    iff2_nxt = iff2_r;
    im_nxt   = im_r;
    unique case (z80acc_pkg::cmd_t'(s1_item_r.cmd))
      z80acc_pkg::CMD_DI: begin
        iff1_nxt = 1'b0;
        iff2_nxt = 1'b0;
      end
      z80acc_pkg::CMD_EI: begin
        iff1_nxt = 1'b1;
        iff2_nxt = 1'b1;
      end
      z80acc_pkg::CMD_IM0: im_nxt = z80acc_pkg::IM_MODE0;
      z80acc_pkg::CMD_IM1: im_nxt = z80acc_pkg::IM_MODE1;
      z80acc_pkg::CMD_IM2: im_nxt = z80acc_pkg::IM_MODE2;
      default: begin
        iff1_nxt = iff1_r;
      end
    endcase
  end

  always_comb begin
    out_item_nxt.acc_out      = acc_res;
    out_item_nxt.flags_out    = flags_res;
    out_item_nxt.iff1_out     = iff1_nxt;
    out_item_nxt.iff2_out     = iff2_nxt;
    out_item_nxt.int_mode_out = im_nxt;
    out_item_nxt.halt_request = (s1_item_r.cmd == z80acc_pkg::CMD_HALT);
    out_item_nxt.ei_executed  = (s1_item_r.cmd == z80acc_pkg::CMD_EI);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      iff1_r      <= 1'b0;
      iff2_r      <= 1'b0;
      im_r        <= z80acc_pkg::IM_MODE0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        iff1_r      <= iff1_nxt;
        iff2_r      <= iff2_nxt;
        im_r        <= im_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/z80acc_alu.sv
// Accumulator and flag datapath: DAA, CPL, NEG, CCF, SCF.
// Depends on z80acc_pkg for the command codes.
`timescale 1ns / 1ps

module z80acc_alu (
  input  logic [3:0] cmd,
  input  logic [7:0] acc,
  input  logic [7:0] flags,
  output logic [7:0] acc_res,
  output logic [7:0] flags_res
);

  logic       daa_hi;
  logic       daa_lo;
  logic [7:0] daa_corr;
  logic [7:0] daa_res;
  logic [7:0] neg_res;
  logic [7:0] cpl_res;

  // flags: S Z Y H X PV N C
  assign daa_hi   = flags[0] | (acc > 8'h99);
  assign daa_lo   = flags[4] | (acc[3:0] > 4'd9);
  assign daa_corr = {1'b0, daa_hi, daa_hi, 1'b0, 1'b0, daa_lo, daa_lo, 1'b0};
  assign daa_res  = flags[1] ? (acc - daa_corr) : (acc + daa_corr);
  assign neg_res  = 8'd0 - acc;
  assign cpl_res  = ~acc;

  always_comb begin
    acc_res   = acc;
    flags_res = flags;
    unique case (z80acc_pkg::cmd_t'(cmd))
      z80acc_pkg::CMD_DAA: begin
        acc_res   = daa_res;
        flags_res = {daa_res[7], daa_res == 8'd0, daa_res[5], acc[4] ^ daa_res[4],
                     daa_res[3], ~^daa_res, flags[1], daa_hi};
      end
      z80acc_pkg::CMD_CPL: begin
        acc_res   = cpl_res;
        flags_res = {flags[7], flags[6], cpl_res[5], 1'b1, cpl_res[3], flags[2],
                     1'b1, flags[0]};
      end
      z80acc_pkg::CMD_NEG: begin
        acc_res   = neg_res;
        flags_res = {neg_res[7], neg_res == 8'd0, neg_res[5], acc[4] ^ neg_res[4],
                     neg_res[3], acc == 8'h80, 1'b1, acc != 8'd0};
      end
      z80acc_pkg::CMD_CCF: begin
        flags_res = {flags[7], flags[6], acc[5], flags[0], acc[3], flags[2],
                     1'b0, ~flags[0]};
      end
      z80acc_pkg::CMD_SCF: begin
        flags_res = {flags[7], flags[6], acc[5], 1'b0, acc[3], flags[2], 1'b0, 1'b1};
      end
      default: begin
        acc_res   = acc;
        flags_res = flags;
      end
    endcase
  end

endmodule

>>> rtl/z80acc_chk.sv
// Port-level checker for the accumulator/flag and interrupt-control block,
// bound to the top level. Depends on z80acc_pkg.
`timescale 1ns / 1ps

module z80acc_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input z80acc_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_iff_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.iff1_out == out_item.iff2_out)
    else $error("IFF1 and IFF2 diverged");

  a_ei_sets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.ei_executed |-> out_item.iff1_out && out_item.iff2_out)
    else $error("EI item without interrupts enabled");

  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.halt_request && out_item.ei_executed))
    else $error("HALT and EI pulses in one item");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.int_mode_out != 2'd3)
    else $error("illegal interrupt mode");

endmodule

bind z80_accumulator_flag_and_int_control z80acc_chk u_z80acc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
